FILE: rtl/core/tkci_pkg.sv
// tkci_pkg: shared types and constants for the top-K count insertion list.
// Used by the cells, the top level and the port checker.
// No dependencies.
package tkci_pkg;

  localparam int unsigned ListDepthDef = 256;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 31;
  localparam int unsigned DateW  = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned RankW  = 8;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned TotalW = 8;

  typedef enum logic [ModeW-1:0] {
    ModeInsert = 2'd0,
    ModeRead   = 2'd1,
    ModeClear  = 2'd2,
    ModeNop    = 2'd3
  } mode_e;

  // input word, last field in the low bits
  typedef struct packed {
    logic              pad;
    logic [RankW-1:0]  read_rank;
    logic [TagW-1:0]   record_tag;
    logic [DateW-1:0]  post_date;
    logic [CountW-1:0] post_count;
  } in_word_t;

  // output word, last field in the low bits
  typedef struct packed {
    logic [TagW-1:0]   out_tag;
    logic [DateW-1:0]  out_date;
    logic [CountW-1:0] out_count;
    logic [TotalW-1:0] entry_total;
    logic [SlotW-1:0]  slot;
    logic              hit;
  } out_word_t;

  localparam int unsigned InDataW  = $bits(in_word_t);
  localparam int unsigned OutDataW = $bits(out_word_t);

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [DateW-1:0]  date;
    logic [TagW-1:0]   tag;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   clr;
    entry_t entry;
  } cell_op_t;

  // one leaf of the readout tree; at most one leaf is nonzero per item
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    entry_t           entry;
  } leaf_t;

endpackage

FILE: rtl/core/tkci_cell.sv
// tkci_cell: one rank of the sorted list; compares its count with the new key
// and either keeps its entry, takes its upper neighbor's, takes the new one, or clears.
// Depends on tkci_pkg.
module tkci_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkci_pkg::cell_op_t op_i,
  input  logic               prev_gt_i,
  input  tkci_pkg::entry_t   prev_entry_i,
  input  logic               rd_sel_i,
  output logic               gt_o,
  output logic               ins_o,
  output tkci_pkg::entry_t   entry_o,
  output tkci_pkg::entry_t   rd_entry_o
);
  import tkci_pkg::*;

  entry_t entry_q, entry_d;

  // list is nonincreasing, so gt is monotone down the chain
  assign gt_o  = op_i.entry.count > entry_q.count;
  assign ins_o = gt_o && !prev_gt_i;

  always_comb begin
    entry_d = entry_q;
    if (op_i.clr) begin
      entry_d = '0;
    end else if (op_i.ins && gt_o) begin
      entry_d = prev_gt_i ? prev_entry_i : op_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o    = entry_q;
  assign rd_entry_o = rd_sel_i ? entry_q : '0;

endmodule

FILE: rtl/core/tkci_or_tree.sv
// tkci_or_tree: registered binary OR tree that collects the one active leaf
// of the cell row; one register level per tree level.
// Depends on nothing beyond its parameters.
module tkci_or_tree #(
  parameter int unsigned Leaves = 256,
  parameter int unsigned W      = 8
) (
  input  logic                      clk_i,
  input  logic [Leaves-1:0][W-1:0]  leaf_i,
  output logic [W-1:0]              root_o
);
  localparam int unsigned Levels = (Leaves > 1) ? $clog2(Leaves) : 1;
  localparam int unsigned Pad    = 1 << Levels;

  // heap numbering: 1..Pad-1 registered nodes, Pad..2*Pad-1 leaves
  logic [W-1:0] nodes  [1:2*Pad-1];
  logic [W-1:0] node_q [1:Pad-1];
  logic [W-1:0] node_d [1:Pad-1];

  for (genvar j = 0; j < Pad; j++) begin : g_leaf
    if (j < Leaves) begin : g_real
      assign nodes[Pad+j] = leaf_i[j];
    end else begin : g_fill
      assign nodes[Pad+j] = '0;
    end
  end

  for (genvar k = 1; k < Pad; k++) begin : g_node
    assign nodes[k]  = node_q[k];
    assign node_d[k] = nodes[2*k] | nodes[2*k+1];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k < Pad; k++) begin
      node_q[k] <= node_d[k];
    end
  end

  assign root_o = node_q[1];

endmodule

FILE: rtl/core/top_k_count_insertion.sv
// top_k_count_insertion: descending top-K list kept in a row of cells.
// Between input accept and m_axis_tvalid a result passes clog2(ListDepth)
// readout tree levels and then the output register; the input takes no
// new word until the previous result has reached the readout tree root, and
// it stays closed longer only while a second result waits behind a stall.
// Reset clears every cell and the entry count; no clearing pass is needed.
module top_k_count_insertion #(
  parameter int unsigned ListDepth = tkci_pkg::ListDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // post_count, post_date, record_tag, read_rank, pad
  input  logic [tkci_pkg::InDataW-1:0]  s_axis_tdata,
  // mode
  input  logic [tkci_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, slot, entry_total, out_count, out_date, out_tag
  output logic [tkci_pkg::OutDataW-1:0] m_axis_tdata
);
  import tkci_pkg::*;

  localparam int unsigned CntW       = $clog2(ListDepth);
  localparam int unsigned TreeLevels = $clog2(ListDepth);
  localparam int unsigned CmpW       = (CntW > RankW) ? CntW : RankW;
  localparam int unsigned LeafW      = $bits(leaf_t);
  localparam logic [CntW-1:0] CntMax = CntW'(ListDepth - 1);

  logic            accept;
  logic            inflight_q;
  logic            go_q;
  logic [TreeLevels-1:0] stage_q;
  mode_e           mode_q;
  in_word_t        item_q;
  logic [CntW-1:0] ve_q, ve_d;

  logic is_ins, is_read, is_clr, rd_hit, res_valid;
  cell_op_t op;

  logic   gt       [ListDepth];
  logic   ins      [ListDepth];
  logic   rd_sel   [ListDepth];
  entry_t cell_ent [ListDepth];
  entry_t rd_ent   [ListDepth];
  logic [ListDepth-1:0][LeafW-1:0] leaf_vec;
  logic [LeafW-1:0] root_vec;
  leaf_t     root;
  out_word_t res;
  out_word_t out_q, hold_q;
  logic      out_valid_q, hold_valid_q, drain;

  assign s_axis_tready = !inflight_q && !hold_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_t'(s_axis_tdata);
      mode_q <= mode_e'(s_axis_tuser);
    end
  end

  assign is_ins  = (mode_q == ModeInsert);
  assign is_read = (mode_q == ModeRead);
  assign is_clr  = (mode_q == ModeClear);
  assign rd_hit  = CmpW'(item_q.read_rank) < CmpW'(ve_q);

  assign op.ins         = go_q && is_ins;
  assign op.clr         = go_q && is_clr;
  assign op.entry.count = item_q.post_count;
  assign op.entry.date  = item_q.post_date;
  assign op.entry.tag   = item_q.record_tag;

  for (genvar i = 0; i < ListDepth; i++) begin : g_cell
    logic   prev_gt;
    entry_t prev_ent;
    leaf_t  leaf;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_ent = '0;
    end else begin : g_link
      assign prev_gt  = gt[i-1];
      assign prev_ent = cell_ent[i-1];
    end

    assign rd_sel[i] = is_read && rd_hit && (CmpW'(item_q.read_rank) == CmpW'(i));

    tkci_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_ent),
      .rd_sel_i     (rd_sel[i]),
      .gt_o         (gt[i]),
      .ins_o        (ins[i]),
      .entry_o      (cell_ent[i]),
      .rd_entry_o   (rd_ent[i])
    );

    assign leaf.hit   = (is_ins && ins[i]) || rd_sel[i];
    assign leaf.slot  = (is_ins && ins[i]) ? SlotW'(i) : '0;
    assign leaf.entry = rd_ent[i];
    assign leaf_vec[i] = leaf;
  end

  // leaves are sampled in the go cycle, before the row updates
  tkci_or_tree #(
    .Leaves (ListDepth),
    .W      (LeafW)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf_vec),
    .root_o (root_vec)
  );

  assign root      = leaf_t'(root_vec);
  assign res_valid = stage_q[TreeLevels-1];

  always_comb begin
    ve_d = ve_q;
    if (go_q) begin
      if (is_clr) begin
        ve_d = '0;
      end else if (is_ins && gt[ListDepth-1] && (ve_q != CntMax)) begin
        ve_d = ve_q + 1'b1;
      end
    end
  end

  always_comb begin
    res.hit         = root.hit;
    res.slot        = is_read ? item_q.read_rank : root.slot;
    res.entry_total = TotalW'(ve_q);
    res.out_count   = root.entry.count;
    res.out_date    = root.entry.date;
    res.out_tag     = root.entry.tag;
  end

  assign drain = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q   <= 1'b0;
      go_q         <= 1'b0;
      stage_q      <= '0;
      ve_q         <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      go_q    <= accept;
      stage_q <= (stage_q << 1) | TreeLevels'(go_q);
      ve_q    <= ve_d;
      if (accept) begin
        inflight_q <= 1'b1;
      end else if (res_valid) begin
        inflight_q <= 1'b0;
      end
      if (hold_valid_q && (!out_valid_q || drain)) begin
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
      end else if (res_valid) begin
        if (!out_valid_q || drain) begin
          out_valid_q <= 1'b1;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (drain) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q && (!out_valid_q || drain)) begin
      out_q <= hold_q;
    end else if (res_valid) begin
      if (!out_valid_q || drain) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: rtl/core/tkci_checker.sv
// tkci_port_props: port-level checks on the top-K list, bound to the top level.
// Depends on tkci_pkg and top_k_count_insertion.
module tkci_port_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tkci_pkg::OutDataW-1:0] m_axis_tdata
);
  import tkci_pkg::*;

  out_word_t  ow;
  logic       s_acc, m_acc;
  logic [1:0] pend_q;

  assign ow    = out_word_t'(m_axis_tdata);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (s_acc && !m_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (m_acc && !s_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_no_orphan_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("output word without an accepted input");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words outstanding");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !ow.hit) |->
      (ow.out_count == '0 && ow.out_date == '0 && ow.out_tag == '0))
    else $error("miss carries nonzero entry data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

endmodule

bind top_k_count_insertion tkci_port_props u_tkci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tkci_checker.sv
// tkci_checker: watches both stream ports of the top-K insertion list,
// predicts every result word and compares it field by field.
// Depends on tkci_pkg.
module tkci_checker #(
  parameter int unsigned ListDepth = tkci_pkg::ListDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [tkci_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [tkci_pkg::ModeW-1:0]    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tkci_pkg::OutDataW-1:0] m_axis_tdata,
  output int                            errors_o,
  output int                            outstanding_o,
  output int                            checked_o,
  output int                            peak_total_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tkci_pkg::*;

  logic [CountW-1:0] rank_count_q [ListDepth];
  logic [DateW-1:0]  rank_date_q  [ListDepth];
  logic [TagW-1:0]   rank_tag_q   [ListDepth];
  int                held_entries;

  out_word_t pending_results[$];

  function void clear_list();
    for (int i = 0; i < ListDepth; i++) begin
      rank_count_q[i] = '0;
      rank_date_q[i]  = '0;
      rank_tag_q[i]   = '0;
    end
    held_entries = 0;
  endfunction

  // applies one input word to the shadow list and returns its result word
  function out_word_t rank_list_update(input in_word_t w, input mode_e m);
    out_word_t r;
    int        pos;
    r   = '0;
    pos = -1;
    case (m)
      ModeInsert: begin
        // the slot just past the counted range is searched too
        for (int i = 0; i <= held_entries; i++) begin
          if (pos < 0 && w.post_count > rank_count_q[i]) pos = i;
        end
        if (pos >= 0) begin
          if (held_entries < ListDepth - 1) held_entries++;
          for (int j = held_entries; j > pos; j--) begin
            rank_count_q[j] = rank_count_q[j-1];
            rank_date_q[j]  = rank_date_q[j-1];
            rank_tag_q[j]   = rank_tag_q[j-1];
          end
          rank_count_q[pos] = w.post_count;
          rank_date_q[pos]  = w.post_date;
          rank_tag_q[pos]   = w.record_tag;
          r.hit  = 1'b1;
          r.slot = SlotW'(pos);
        end
      end
      ModeRead: begin
        r.slot = w.read_rank;
        if (int'(w.read_rank) < held_entries) begin
          r.hit       = 1'b1;
          r.out_count = rank_count_q[w.read_rank];
          r.out_date  = rank_date_q[w.read_rank];
          r.out_tag   = rank_tag_q[w.read_rank];
        end
      end
      ModeClear: clear_list();
      default: ;
    endcase
    r.entry_total = TotalW'(held_entries);
    if (held_entries > peak_total_o) peak_total_o = held_entries;
    return r;
  endfunction

  out_word_t got_word;
  out_word_t want_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_list();
      pending_results.delete();
      errors_o      = 0;
      outstanding_o = 0;
      checked_o     = 0;
      peak_total_o  = 0;
    end else begin
      // output side first: a word accepted now cannot stem from this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = out_word_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result word with nothing expected: %h", $realtime, got_word);
        end else begin
          want_word = pending_results.pop_front();
          checked_o++;
          if (got_word.hit !== want_word.hit || got_word.slot !== want_word.slot ||
              got_word.entry_total !== want_word.entry_total ||
              got_word.out_count !== want_word.out_count ||
              got_word.out_date !== want_word.out_date ||
              got_word.out_tag !== want_word.out_tag) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch exp hit=%0d slot=%0d total=%0d cnt=%h date=%h tag=%h",
                       $realtime, want_word.hit, want_word.slot, want_word.entry_total,
                       want_word.out_count, want_word.out_date, want_word.out_tag);
              $display("%0t:          got hit=%0d slot=%0d total=%0d cnt=%h date=%h tag=%h",
                       $realtime, got_word.hit, got_word.slot, got_word.entry_total,
                       got_word.out_count, got_word.out_date, got_word.out_tag);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(rank_list_update(in_word_t'(s_axis_tdata),
                                                   mode_e'(s_axis_tuser)));
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for top_k_count_insertion.
// Drives directed and random words with random gaps and back-pressure;
// prediction and comparison live in tkci_checker. Depends on tkci_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkci_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int WatchLimit  = 4000;
  localparam int RandomItems = 1800;
  localparam int TailCycles  = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ModeW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  int errors;
  int outstanding;
  int checked;
  int peak_total;

  int tally [4];
  int ins_since_clr;
  bit calm;
  int sink_left;
  int sink_pick;
  int idle_cycles;

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  top_k_count_insertion #(
    .ListDepth(ListDepthDef)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tkci_checker #(
    .ListDepth(ListDepthDef)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors_o     (errors),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .peak_total_o (peak_total)
  );

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (sink_left > 0) begin
      sink_left <= sink_left - 1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_pick = $urandom_range(0, 19);
      if (sink_pick < 10) begin
        m_axis_tready <= 1'b1;
        sink_left     <= $urandom_range(0, 15);
      end else if (sink_pick < 18) begin
        m_axis_tready <= 1'b0;
        sink_left     <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        sink_left     <= $urandom_range(19, 49);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchLimit) begin
          $display("timeout: no word moved for %0d cycles", WatchLimit);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_word(input mode_e m, input logic [CountW-1:0] cnt,
                           input logic [DateW-1:0] date, input logic [TagW-1:0] tag,
                           input logic [RankW-1:0] rank);
    in_word_t w;
    int       gap;
    int       pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(15, 60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    w.pad        = 1'b0;
    w.read_rank  = rank;
    w.record_tag = tag;
    w.post_date  = date;
    w.post_count = cnt;
    s_axis_tdata  <= w;
    s_axis_tuser  <= m;
    s_axis_tvalid <= 1'b1;
    tally[int'(m)]++;
    if (m == ModeInsert) ins_since_clr++;
    else if (m == ModeClear) ins_since_clr = 0;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  // keys lean toward small values so ties and rejects show up often
  task automatic random_item(input int ins_pct, input int rd_pct, input int clr_pct);
    int                pick;
    int                kind;
    logic [CountW-1:0] cnt;
    logic [RankW-1:0]  rank;
    mode_e             m;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) m = ModeInsert;
    else if (pick < ins_pct + rd_pct) m = ModeRead;
    else if (pick < ins_pct + rd_pct + clr_pct) m = ModeClear;
    else m = ModeNop;
    kind = $urandom_range(0, 99);
    if (kind < 4) cnt = '0;
    else if (kind < 34) cnt = CountW'($urandom_range(1, 31));
    else if (kind < 44) cnt = {CountW{1'b1}} - CountW'($urandom_range(0, 255));
    else cnt = CountW'($urandom);
    if ($urandom_range(0, 9) < 7)
      rank = RankW'($urandom_range(0, (ins_since_clr < 255) ? ins_since_clr : 255));
    else
      rank = RankW'($urandom_range(0, 255));
    send_word(m, cnt, $urandom, TagW'($urandom), rank);
  endtask

  initial begin
    int directed_n;
    int kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeNop;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    sink_left     = 0;
    idle_cycles   = 0;
    ins_since_clr = 0;
    foreach (tally[i]) tally[i] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: reads miss, zero key is refused
    send_word(ModeRead, '0, '0, '0, 8'd0);
    send_word(ModeRead, '0, '0, '0, 8'd255);
    send_word(ModeInsert, '0, '1, '1, '0);
    send_word(ModeInsert, '1, '1, '1, '0);
    send_word(ModeInsert, CountW'(1), '0, '0, '1);
    // equal keys land behind the ones already held
    send_word(ModeInsert, CountW'(1), 32'h1234_5678, 16'h00aa, '0);
    send_word(ModeInsert, '1, 32'h8765_4321, 16'h5500, '0);
    send_word(ModeInsert, CountW'(500), 32'hdead_beef, 16'hcafe, '0);
    send_word(ModeInsert, '0, '1, '1, '1);
    for (int r = 0; r < 6; r++) send_word(ModeRead, '1, '1, '1, RankW'(r));
    send_word(ModeNop, CountW'($urandom), $urandom, TagW'($urandom), RankW'($urandom));
    send_word(ModeRead, '0, '0, '0, 8'd255);
    send_word(ModeClear, '1, '1, '1, '1);
    send_word(ModeRead, '0, '0, '0, 8'd0);
    send_word(ModeNop, '1, '1, '1, '1);
    send_word(ModeInsert, CountW'(1), '1, '0, '0);
    send_word(ModeRead, '0, '0, '0, 8'd0);
    send_word(ModeClear, '0, '0, '0, '0);
    wait_results_done();
    directed_n = tally[0] + tally[1] + tally[2] + tally[3];

    // fill past full depth so the last slot gets pushed out and overwritten
    repeat (400) random_item(80, 15, 0);
    wait_results_done();

    while (tally[0] + tally[1] + tally[2] + tally[3] - directed_n < RandomItems) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 4) == 0);
      if (kind < 2) begin
        send_word(ModeClear, CountW'($urandom), $urandom, TagW'($urandom), RankW'($urandom));
        repeat (300) random_item(80, 15, 0);
      end else if (kind < 8) begin
        repeat ($urandom_range(10, 60)) random_item(55, 35, 4);
      end else begin
        repeat ($urandom_range(5, 30)) random_item(25, 25, 25);
      end
      if ($urandom_range(0, 3) == 0) wait_results_done();
    end

    calm = 1'b0;
    wait_results_done();
    repeat (TailCycles) @(negedge clk_i);

    $display("Stimulus: %0d words (%0d insert, %0d read, %0d clear, %0d no-op)",
             tally[0] + tally[1] + tally[2] + tally[3], tally[0], tally[1], tally[2],
             tally[3]);
    $display("Checked %0d result words, list held up to %0d entries, %0d mismatches",
             checked, peak_total, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
